// ----- sv/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types, constants and tables of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int CELL_DEPTH   = 4096;
	localparam int TAB_WIDTH    = 8;
	localparam int MAX_COLS     = 80;
	localparam int MAX_ROWS     = 50;
	localparam int SCREEN_CELLS = MAX_COLS * MAX_ROWS;
	localparam int CELL_AW      = $clog2(CELL_DEPTH);
	localparam int IDX_W        = $clog2(((CELL_DEPTH > SCREEN_CELLS) ?
		CELL_DEPTH : SCREEN_CELLS) + 1);

	localparam int COL_W  = 7;
	localparam int ROW_W  = 6;
	localparam int CHR_W  = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = 16;
	localparam int RADR_W = 12;
	localparam int LOC_W  = 12;
	localparam int KIND_W = 2;

	localparam int NUM_REGS = 3;
	localparam int PADDR_W  = $clog2(NUM_REGS * 4);
	localparam int PDATA_W  = 32;
	localparam int REG_IW   = PADDR_W - 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

	localparam logic [ATTR_W-1:0] RST_COLOR = 8'd15;
	localparam logic [COL_W-1:0]  RST_COLS  = 7'd80;
	localparam logic [ROW_W-1:0]  RST_ROWS  = 6'd25;

	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	localparam logic [CHR_W-1:0] CHR_BS  = 8'd8;
	localparam logic [CHR_W-1:0] CHR_TAB = 8'd9;
	localparam logic [CHR_W-1:0] CHR_NL  = 8'd10;
	localparam logic [CHR_W-1:0] CHR_CR  = 8'd13;

	localparam logic [REG_IW-1:0] REG_COLOR = 2'd0;
	localparam logic [REG_IW-1:0] REG_COLS  = 2'd1;
	localparam logic [REG_IW-1:0] REG_ROWS  = 2'd2;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_BS,
		OP_CR,
		OP_NL,
		OP_TAB,
		OP_PUT,
		OP_CLEAR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CHR_W-1:0]  chr;
		logic [RADR_W-1:0] addr;
		logic              eow;
	} req_t;

	typedef struct packed {
		logic [ATTR_W-1:0] color;
		logic [COL_W-1:0]  ncols;
		logic [ROW_W-1:0]  nrows;
	} cfg_t;

	typedef logic [(1 << COL_W)-1:0][COL_W-1:0] tab_tbl_t;

	// first tab stop at or after every column, capped at the widest line
	function automatic tab_tbl_t make_tab_table();
		tab_tbl_t tbl;
		int       t;
		for (int i = 0; i < (1 << COL_W); i++) begin
			t = ((i + TAB_WIDTH - 1) / TAB_WIDTH) * TAB_WIDTH;
			if (t > MAX_COLS) begin
				t = MAX_COLS;
			end
			tbl[i] = COL_W'(t);
		end
		return tbl;
	endfunction

	localparam tab_tbl_t TAB_STOP = make_tab_table();

endpackage

// ----- sv/tcw_front.sv -----
// ----------------------------------------------------------------------------
// tcw_front
// request intake: decodes each request into an operation and queues it
// ----------------------------------------------------------------------------
module tcw_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tcw_pkg::KIND_W-1:0]  kind,
	input  logic [tcw_pkg::CHR_W-1:0]   char_code,
	input  logic [tcw_pkg::RADR_W-1:0]  read_address,
	input  logic                        end_of_write,
	input  logic                        init_done,
	output logic                        q_valid,
	output tcw_pkg::req_t               q_req,
	input  logic                        q_pop
);
	import tcw_pkg::*;

	req_t                req_d;
	req_t                fifo_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] cnt_q;
	logic                push;

	always_comb begin
		req_d.chr  = char_code;
		req_d.addr = read_address;
		req_d.eow  = end_of_write;
		unique case (kind)
			KIND_WRITE: begin
				unique case (char_code)
					CHR_BS:  req_d.op = OP_BS;
					CHR_TAB: req_d.op = OP_TAB;
					CHR_NL:  req_d.op = OP_NL;
					CHR_CR:  req_d.op = OP_CR;
					default: req_d.op = OP_PUT;
				endcase
			end
			KIND_CLEAR: req_d.op = OP_CLEAR;
			KIND_READ:  req_d.op = OP_READ;
			default:    req_d.op = OP_NOP;
		endcase
	end

	assign in_ready = init_done && (cnt_q != QUEUE_CW'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_req    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= req_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			priority if (push && !q_pop) begin
				cnt_q <= cnt_q + QUEUE_CW'(1);
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - QUEUE_CW'(1);
			end
		end
	end

endmodule

// ----- sv/tcw_back.sv -----
// ----------------------------------------------------------------------------
// tcw_back
// execution engine: cursor, cell memory, scroll and clear sweeps, result reg
// ----------------------------------------------------------------------------
module tcw_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcw_pkg::cfg_t               cfg,
	input  logic                        q_valid,
	input  tcw_pkg::req_t               q_req,
	output logic                        q_pop,
	output logic                        init_done,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tcw_pkg::CELL_W-1:0]  cell_value,
	output logic [tcw_pkg::LOC_W-1:0]   cursor_location,
	output logic                        cursor_update,
	output logic                        scrolled,
	output logic [tcw_pkg::COL_W-1:0]   column_now,
	output logic [tcw_pkg::ROW_W-1:0]   row_now,
	output logic                        write_done
);
	import tcw_pkg::*;

	typedef enum logic [7:0] {
		S_INIT   = 8'b00000001,
		S_IDLE   = 8'b00000010,
		S_EXEC   = 8'b00000100,
		S_COPY   = 8'b00001000,
		S_FILL   = 8'b00010000,
		S_PUT    = 8'b00100000,
		S_CLEAR  = 8'b01000000,
		S_RDWAIT = 8'b10000000
	} state_t;

	typedef struct packed {
		logic [CELL_W-1:0] cval;
		logic [LOC_W-1:0]  loc;
		logic              upd;
		logic              scr;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic              eow;
	} res_t;

	logic [CELL_W-1:0] mem [CELL_DEPTH];

	state_t            state_q, state_d;
	req_t              op_q, op_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [IDX_W-1:0]  base_q, base_d;
	logic [IDX_W-1:0]  cnt_q, cnt_d;
	logic              scr_q, scr_d;
	logic              pend_s1;
	logic [IDX_W-1:0]  waddr_s1;
	logic              rdok_s1;
	logic [CELL_W-1:0] rdata_q;
	logic              out_valid_q;
	res_t              res_q, res_d;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [CELL_W-1:0] wr_data;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              emit;
	logic              issue;
	logic              slot_free;

	logic              wrap;
	logic [ROW_W:0]    row_p1;
	logic [ROW_W-1:0]  row_inc;
	logic [COL_W-1:0]  col1;
	logic [ROW_W-1:0]  row1;
	logic              need_scroll;
	logic [ROW_W-1:0]  row2;
	logic [ROW_W-1:0]  mul_row;
	logic [IDX_W-1:0]  prod;
	logic [COL_W-1:0]  tab_col;
	logic [IDX_W-1:0]  put_addr;
	logic [IDX_W-1:0]  fill_end;

	assign slot_free = !out_valid_q || out_ready;
	assign init_done = (state_q != S_INIT);

	// cursor and sweep arithmetic shared by the decode, copy, fill, put and clear steps
	always_comb begin
		wrap        = (col_q >= cfg.ncols);
		row_p1      = {1'b0, row_q} + (ROW_W+1)'(1);
		row_inc     = (row_p1 >= {1'b0, cfg.nrows}) ? cfg.nrows : row_p1[ROW_W-1:0];
		col1        = wrap ? '0 : col_q;
		row1        = wrap ? row_inc : row_q;
		need_scroll = (row1 >= cfg.nrows);
		row2        = need_scroll ? (cfg.nrows - ROW_W'(1)) : row1;
		mul_row     = (op_q.op == OP_CLEAR) ? cfg.nrows : row2;
		prod        = IDX_W'(mul_row) * IDX_W'(cfg.ncols);
		tab_col     = (TAB_STOP[col_q] > cfg.ncols) ? cfg.ncols : TAB_STOP[col_q];
		put_addr    = base_q + IDX_W'(col_q);
		fill_end    = base_q + IDX_W'(cfg.ncols);
		issue       = (cnt_q < base_q);
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		col_d   = col_q;
		row_d   = row_q;
		base_d  = base_q;
		cnt_d   = cnt_q;
		scr_d   = scr_q;
		wr_en   = 1'b0;
		wr_addr = cnt_q;
		wr_data = BLANK_CELL;
		rd_en   = 1'b0;
		rd_addr = cnt_q;
		q_pop   = 1'b0;
		emit    = 1'b0;
		res_d   = '0;
		unique case (state_q)
			S_INIT: begin
				wr_en = 1'b1;
				cnt_d = cnt_q + IDX_W'(1);
				if (cnt_q == IDX_W'(CELL_DEPTH - 1)) begin
					cnt_d   = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					op_d    = q_req;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (op_q.op)
					OP_PUT: begin
						col_d   = col1;
						row_d   = row2;
						base_d  = prod;
						scr_d   = need_scroll;
						cnt_d   = '0;
						state_d = need_scroll ? S_COPY : S_PUT;
					end
					OP_CLEAR: begin
						base_d  = prod;
						cnt_d   = '0;
						state_d = S_CLEAR;
					end
					OP_READ: begin
						rd_en   = 1'b1;
						rd_addr = IDX_W'(op_q.addr);
						state_d = S_RDWAIT;
					end
					OP_BS, OP_CR, OP_NL, OP_TAB, OP_NOP: begin
						if (slot_free) begin
							unique case (op_q.op)
								OP_BS: begin
									if (col_q != '0) begin
										col_d = col_q - COL_W'(1);
									end
								end
								OP_CR:  col_d = '0;
								OP_NL: begin
									col_d = '0;
									row_d = row_inc;
								end
								OP_TAB: col_d = tab_col;
								default: ;
							endcase
							emit    = 1'b1;
							state_d = S_IDLE;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_COPY: begin
				if (pend_s1) begin
					wr_en   = 1'b1;
					wr_addr = waddr_s1;
					wr_data = rdok_s1 ? rdata_q : BLANK_CELL;
				end
				if (issue) begin
					rd_en   = 1'b1;
					rd_addr = cnt_q + IDX_W'(cfg.ncols);
					cnt_d   = cnt_q + IDX_W'(1);
				end else if (!pend_s1) begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				if (cnt_q < fill_end) begin
					wr_en = 1'b1;
					cnt_d = cnt_q + IDX_W'(1);
				end else begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				if (slot_free) begin
					wr_en     = 1'b1;
					wr_addr   = put_addr;
					wr_data   = {cfg.color, op_q.chr};
					col_d     = col_q + COL_W'(1);
					emit      = 1'b1;
					res_d.loc = LOC_W'(put_addr + IDX_W'(1));
					res_d.upd = 1'b1;
					res_d.scr = scr_q;
					state_d   = S_IDLE;
				end
			end
			S_CLEAR: begin
				if (issue) begin
					wr_en = 1'b1;
					cnt_d = cnt_q + IDX_W'(1);
				end else if (slot_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RDWAIT: begin
				if (slot_free) begin
					res_d.cval = rdok_s1 ? rdata_q : '0;
					emit       = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		res_d.col = col_d;
		res_d.row = row_d;
		res_d.eow = op_q.eow;
	end

	// cell memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr < IDX_W'(CELL_DEPTH))) begin
			mem[wr_addr[CELL_AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr[CELL_AW-1:0]];
			rdok_s1 <= (rd_addr < IDX_W'(CELL_DEPTH));
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		base_q   <= base_d;
		waddr_s1 <= cnt_q;
		if (emit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			col_q       <= '0;
			row_q       <= '0;
			cnt_q       <= '0;
			scr_q       <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			cnt_q   <= cnt_d;
			scr_q   <= scr_d;
			pend_s1 <= (state_q == S_COPY) && issue;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign cell_value      = res_q.cval;
	assign cursor_location = res_q.loc;
	assign cursor_update   = res_q.upd;
	assign scrolled        = res_q.scr;
	assign column_now      = res_q.col;
	assign row_now         = res_q.row;
	assign write_done      = res_q.eow;

endmodule

// ----- sv/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// flow: a control or no-op request passes the idle and decode steps of the
// execution engine, a read adds a memory read, a printable character a put
// step, after copy and fill sweeps when it scrolls; a clear sweeps the screen
// the engine takes a queued request only once the last one is done, and it
// waits while a result is still held for out_ready
// reset: cursor to the top left, registers to defaults; an init pass then
// blanks all 4096 cells of the cell memory while in_ready stays low
// ----------------------------------------------------------------------------
module text_console_writer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tcw_pkg::PADDR_W-1:0]  paddr,
	input  logic [tcw_pkg::PDATA_W-1:0]  pwdata,
	output logic [tcw_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tcw_pkg::KIND_W-1:0]   kind,
	input  logic [tcw_pkg::CHR_W-1:0]    char_code,
	input  logic [tcw_pkg::RADR_W-1:0]   read_address,
	input  logic                         end_of_write,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tcw_pkg::CELL_W-1:0]   cell_value,
	output logic [tcw_pkg::LOC_W-1:0]    cursor_location,
	output logic                         cursor_update,
	output logic                         scrolled,
	output logic [tcw_pkg::COL_W-1:0]    column_now,
	output logic [tcw_pkg::ROW_W-1:0]    row_now,
	output logic                         write_done
);
	import tcw_pkg::*;

	logic [ATTR_W-1:0] color_q;
	logic [COL_W-1:0]  cols_q;
	logic [ROW_W-1:0]  rows_q;
	logic [REG_IW-1:0] reg_idx;
	logic              reg_wr;
	cfg_t              cfg;
	logic              q_valid;
	req_t              q_req;
	logic              q_pop;
	logic              init_done;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= RST_COLOR;
			cols_q  <= RST_COLS;
			rows_q  <= RST_ROWS;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_COLOR: color_q <= pwdata[ATTR_W-1:0];
				REG_COLS:  cols_q  <= pwdata[COL_W-1:0];
				REG_ROWS:  rows_q  <= pwdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_COLOR: prdata = PDATA_W'(color_q);
			REG_COLS:  prdata = PDATA_W'(cols_q);
			REG_ROWS:  prdata = PDATA_W'(rows_q);
			default:   prdata = '0;
		endcase
	end

	// geometry clamped to the supported screen
	always_comb begin
		cfg.color = color_q;
		priority if (cols_q == '0) begin
			cfg.ncols = COL_W'(1);
		end else if (cols_q > COL_W'(MAX_COLS)) begin
			cfg.ncols = COL_W'(MAX_COLS);
		end else begin
			cfg.ncols = cols_q;
		end
		priority if (rows_q == '0) begin
			cfg.nrows = ROW_W'(1);
		end else if (rows_q > ROW_W'(MAX_ROWS)) begin
			cfg.nrows = ROW_W'(MAX_ROWS);
		end else begin
			cfg.nrows = rows_q;
		end
	end

	tcw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.char_code    (char_code),
		.read_address (read_address),
		.end_of_write (end_of_write),
		.init_done    (init_done),
		.q_valid      (q_valid),
		.q_req        (q_req),
		.q_pop        (q_pop)
	);

	tcw_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.q_valid         (q_valid),
		.q_req           (q_req),
		.q_pop           (q_pop),
		.init_done       (init_done),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.cell_value      (cell_value),
		.cursor_location (cursor_location),
		.cursor_update   (cursor_update),
		.scrolled        (scrolled),
		.column_now      (column_now),
		.row_now         (row_now),
		.write_done      (write_done)
	);

endmodule

// ----- sv/tcw_checker.sv -----
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks on the result channel of the text console writer
// ----------------------------------------------------------------------------
module tcw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] cell_value,
	input logic [11:0] cursor_location,
	input logic        cursor_update,
	input logic        scrolled,
	input logic [6:0]  column_now,
	input logic [5:0]  row_now,
	input logic        write_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(cell_value) && $stable(cursor_location) &&
		$stable(cursor_update) && $stable(scrolled) && $stable(column_now) &&
		$stable(row_now) && $stable(write_done))
		else $error("stalled result changed");

	a_put_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cursor_update |-> cell_value == 16'h0000 && column_now != 7'd0)
		else $error("printable result with cell data or cursor at column zero");

	a_scroll_put: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scrolled |-> cursor_update)
		else $error("scroll reported without a printable character");

	a_loc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cursor_update |-> cursor_location == 12'd0)
		else $error("cursor location reported without a cursor move");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
